// File: design/mhpq_pkg.sv
// Shared types and constants of the max-heap priority queue.
package mhpq_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned DataW       = 32;
  localparam int unsigned StatW       = 2;
  localparam int unsigned CountOutW   = 7;

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } op_e;

  typedef enum logic [StatW-1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

endpackage

// File: design/mhpq_in_if.sv
// Request channel of the max-heap priority queue: operation and value.
interface mhpq_in_if import mhpq_pkg::*; ();
  logic         valid;
  logic         ready;
  logic         operation;
  data_t        value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// File: design/mhpq_out_if.sv
// Result channel of the max-heap priority queue: status, top value, entry count.
interface mhpq_out_if import mhpq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [StatW-1:0]     status;
  data_t                top_value;
  logic [CountOutW-1:0] entry_count;

  modport source (output valid, output status, output top_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input top_value, input entry_count,
                  output ready);
endinterface

// File: design/max_heap_priority_queue.sv
// Binary max-heap priority queue held in one synchronous memory.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   operation (0 insert, 1 remove max), value (s32)
//   out_o    out  valid/ready   status (2b), top_value (s32), entry_count (7b)
//
// One request at a time. A rejected insert (full), an insert into an empty heap,
// a removal on an empty heap and a removal of the only entry complete at the
// accept edge. Any other insert moves the hole up level by level in S_UP, with
// S_PLACE at the root; any other removal reads the last entry in S_LAST and then
// sinks it level by level in S_DOWN. At each level the memory read of
// parent/children is issued while the previous level's write lands. No clearing
// pass: reset zeroes the count, the state and the output valid, not the memory.
// A result waits in the output register; a new request is taken once it is gone
// or being taken in the same cycle.
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  mhpq_in_if.sink    in_i,
  mhpq_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  // Positions are one-based; one extra bit holds 2*pos+1 without wrap.
  localparam int unsigned PosW = CntW + 1;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [PosW-1:0] pos_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,     // parent data in rd_a_q, compare and move hole up
    S_PLACE,  // hole reached the root, drop value there
    S_LAST,   // last entry in rd_a_q, becomes the sinking value
    S_DOWN    // children in rd_a_q / rd_b_q, compare and move hole down
  } state_e;

  // heap storage, position p lives at address p-1
  data_t mem [CAPACITY];
  data_t rd_a_q, rd_b_q;

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;
  pos_t   pos_q, pos_d;
  data_t  val_q, val_d;
  data_t  top_q, top_d;

  logic                 out_valid_q, out_valid_d;
  logic [StatW-1:0]     out_status_q, out_status_d;
  data_t                out_top_q, out_top_d;
  logic [CountOutW-1:0] out_count_q, out_count_d;

  logic    in_ready, accept, done;
  status_e status_r;
  logic    we;
  idx_t    waddr, raddr_a, raddr_b;
  data_t   wdata;

  // sift-down helpers
  pos_t  left, right, best, up_par, cnt_pos;
  logic  l_gt, r_gt;
  data_t best_val;

  assign in_ready   = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  assign cnt_pos  = PosW'(cnt_q);
  assign left     = pos_q << 1;
  assign right    = left + pos_t'(1);
  assign up_par   = pos_q >> 1;
  assign l_gt     = (left <= cnt_pos) && (val_q < rd_a_q);
  assign best_val = l_gt ? rd_a_q : val_q;
  assign r_gt     = (right <= cnt_pos) && (best_val < rd_b_q);
  assign best     = r_gt ? right : left;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    val_d    = val_q;
    done     = 1'b0;
    status_r = StDone;
    we       = 1'b0;
    waddr    = '0;
    wdata    = val_q;
    raddr_a  = '0;
    raddr_b  = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.operation == OpInsert) begin
            if (cnt_q == cnt_t'(CAPACITY)) begin
              done     = 1'b1;
              status_r = StFull;
            end else begin
              cnt_d = cnt_q + cnt_t'(1);
              pos_d = cnt_pos + pos_t'(1);
              val_d = in_i.value;
              if (cnt_q == '0) begin
                we    = 1'b1;
                waddr = '0;
                wdata = in_i.value;
                done  = 1'b1;
              end else begin
                // parent of the new slot: (cnt+1)/2, address one less
                raddr_a = IdxW'(((cnt_pos + pos_t'(1)) >> 1) - pos_t'(1));
                state_d = S_UP;
              end
            end
          end else begin
            if (cnt_q == '0) begin
              done     = 1'b1;
              status_r = StEmpty;
            end else begin
              cnt_d = cnt_q - cnt_t'(1);
              if (cnt_q == cnt_t'(1)) begin
                done = 1'b1;
              end else begin
                raddr_a = IdxW'(cnt_q - cnt_t'(1));
                state_d = S_LAST;
              end
            end
          end
        end
      end

      S_UP: begin
        we    = 1'b1;
        waddr = IdxW'(pos_q - pos_t'(1));
        if (rd_a_q < val_q) begin
          // parent slides down into the hole
          wdata = rd_a_q;
          pos_d = up_par;
          if (up_par == pos_t'(1)) begin
            state_d = S_PLACE;
          end else begin
            raddr_a = IdxW'((up_par >> 1) - pos_t'(1));
          end
        end else begin
          wdata   = val_q;
          done    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_PLACE: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        done    = 1'b1;
        state_d = S_IDLE;
      end

      S_LAST: begin
        val_d   = rd_a_q;
        pos_d   = pos_t'(1);
        raddr_a = IdxW'(1);
        raddr_b = IdxW'(2);
        state_d = S_DOWN;
      end

      S_DOWN: begin
        we    = 1'b1;
        waddr = IdxW'(pos_q - pos_t'(1));
        if (l_gt || r_gt) begin
          // larger child slides up into the hole
          wdata   = r_gt ? rd_b_q : rd_a_q;
          pos_d   = best;
          raddr_a = IdxW'((best << 1) - pos_t'(1));
          raddr_b = IdxW'(best << 1);
        end else begin
          wdata   = val_q;
          done    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // root copy kept in a register so the result needs no extra read
  always_comb begin
    top_d = top_q;
    if (we && (waddr == '0)) begin
      top_d = wdata;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_top_d    = out_top_q;
    out_count_d  = out_count_q;
    if (done) begin
      out_valid_d  = 1'b1;
      out_status_d = status_r;
      out_top_d    = (cnt_d == '0) ? data_t'(0) : top_d;
      out_count_d  = CountOutW'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    val_q        <= val_d;
    top_q        <= top_d;
    out_status_q <= out_status_d;
    out_top_q    <= out_top_d;
    out_count_q  <= out_count_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.top_value   = out_top_q;
  assign out_o.entry_count = out_count_q;

endmodule
